FILE: sv/gdr_pkg.sv
// ----------------------------------------------------------------------------
// gdr_pkg
// Shared codes, fixed-point constants and helpers for the gated delta rule
// recurrence block.
// ----------------------------------------------------------------------------
`default_nettype none

package gdr_pkg;

  // Request operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_TOKEN = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Result kinds
  localparam logic KIND_ATTN = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_PER_ROW  = 2'd0;
  localparam logic [1:0] CFG_BETA_SIG = 2'd1;
  localparam logic [1:0] CFG_SCALE    = 2'd2;

  localparam logic [16:0] SCALE_RESET = 17'd8192;

  // Exp approximation constants, 30 fractional bits
  localparam logic signed [33:0] LOG2E_Q30 = 34'sd1549082005;
  localparam logic signed [33:0] EXP_C1    = 34'sd704911507;
  localparam logic signed [33:0] EXP_C2    = 34'sd368830317;
  localparam logic [31:0]        ONE_Q30   = 32'd1073741824;

  localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Clamp a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'(x);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/gdr_ram.sv
// ----------------------------------------------------------------------------
// gdr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gdr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire [WIDTH-1:0]           wdata_i,
  input  wire [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: sv/gdr_div.sv
// ----------------------------------------------------------------------------
// gdr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gdr_div
  import gdr_pkg::*;
#(
  parameter int NW = 64,
  parameter int DW = 32
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  wire [NW-1:0]     num_i,
  input  wire [DW-1:0]     den_i,
  output logic [NW-1:0]    quot_o,
  output div_stat_t        stat_o
);

  localparam int CW = $clog2(NW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] num_q, num_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW:0]   rem_sh;
  logic          ge;

  // Shift in one numerator bit, subtract when it fits
  always_comb begin
    rem_sh = {rem_q, num_q[NW-1]};
    ge     = (rem_sh >= {1'b0, den_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? DW'(rem_sh - {1'b0, den_q}) : DW'(rem_sh);
      num_d = {num_q[NW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quot_o      = num_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

FILE: sv/gated_delta_rule_recurrence.sv
// A state write and a token row are written to RAM as they are taken; a state read passes
// through S_RD and S_RDOUT into the output register. One 34x34 multiplier does all the
// multiplications of a token update; the sigmoid on beta adds an exp and a divide.
// One request at a time; tready stays low while an update runs.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes the state RAM,
// all 2**(2*clog2(DIM)) words, with tready low.
// ----------------------------------------------------------------------------
// gated_delta_rule_recurrence
// One head of the gated delta rule recurrence, Q16.16 fixed point, built
// around one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module gated_delta_rule_recurrence
  import gdr_pkg::*;
#(
  parameter int DIM       = 64,
  parameter int FRAC_BITS = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // row[5:0] col[11:6] query_elem[43:12] key_elem[75:44] value_elem[107:76]
  // gate_logit[139:108] beta_logit[171:140] state_elem[203:172], zero pad above
  input  wire [207:0]  s_axis_tdata,
  // operation[1:0]
  input  wire [1:0]    s_axis_tuser,
  input  wire          s_axis_tlast,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // index[5:0] result_value[37:6], zero pad above
  output logic [39:0]  m_axis_tdata,
  // kind[0]
  output logic         m_axis_tuser,
  output logic         m_axis_tlast,
  input  wire          cfg_we_i,
  input  wire [1:0]    cfg_index_i,
  input  wire [16:0]   cfg_data_i
);

  localparam int AW = $clog2(DIM);
  localparam int SW = 2 * AW;
  localparam int SDEPTH = 1 << SW;
  localparam logic signed [33:0] ONE_FX = 34'sd1 <<< FRAC_BITS;
  localparam logic [31:0] ONE_U = 32'd1 << FRAC_BITS;

  // Sequencer states
  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_RDOUT  = 4'd3;
  localparam logic [3:0] S_BETA   = 4'd4;
  localparam logic [3:0] S_EXP    = 4'd5;
  localparam logic [3:0] S_EXPRET = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_GATE   = 4'd8;
  localparam logic [3:0] S_KQ     = 4'd9;
  localparam logic [3:0] S_A      = 4'd10;
  localparam logic [3:0] S_FIX    = 4'd11;
  localparam logic [3:0] S_B      = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  // Request fields
  logic [1:0]         in_op;
  logic [5:0]         in_row, in_col;
  logic [31:0]        in_q, in_k, in_v, in_gate, in_beta, in_state;
  logic               in_acc, addr_ok, row_ok;
  logic [SW-1:0]      in_addr;

  assign in_op    = s_axis_tuser;
  assign in_row   = s_axis_tdata[5:0];
  assign in_col   = s_axis_tdata[11:6];
  assign in_q     = s_axis_tdata[43:12];
  assign in_k     = s_axis_tdata[75:44];
  assign in_v     = s_axis_tdata[107:76];
  assign in_gate  = s_axis_tdata[139:108];
  assign in_beta  = s_axis_tdata[171:140];
  assign in_state = s_axis_tdata[203:172];
  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign row_ok   = ({1'b0, in_row} < 7'(DIM));
  assign addr_ok  = row_ok & ({1'b0, in_col} < 7'(DIM));
  assign in_addr  = {in_row[AW-1:0], in_col[AW-1:0]};

  // Control registers
  logic [3:0]    state_q, state_d;
  logic [2:0]    sub_q, sub_d;
  logic [AW-1:0] i_q, i_d, col_q, col_d;
  logic [SW-1:0] clr_q, clr_d;
  logic          per_row_q, per_row_d, sig_q, sig_d, exp_beta_q, exp_beta_d;
  logic [16:0]   scale_q, scale_d;
  logic signed [31:0] beta_q, beta_d;
  logic          out_valid_q, out_valid_d;

  // Datapath registers
  logic signed [31:0] beta_eff_q, beta_eff_d, g0_q, g0_d, kq_q, kq_d;
  logic signed [31:0] kv_q, kv_d, qs_q, qs_d, d_q, d_d, t_q, t_d;
  logic signed [31:0] s_q, s_d, delta_q, delta_d;
  logic signed [63:0] acc_a_q, acc_a_d, acc_b_q, acc_b_d;
  logic signed [32:0] x_q, x_d;
  logic signed [33:0] n_q, n_d;
  logic [29:0]        f30_q, f30_d, sq_q, sq_d;
  logic [31:0]        pacc_q, pacc_d, exp_q, exp_d;
  logic [SW-1:0]      rd_addr_q, rd_addr_d;
  logic               rd_ok_q, rd_ok_d;
  logic [5:0]         rd_col_q, rd_col_d;
  logic signed [67:0] prod_q, prod_d;
  logic               out_kind_q, out_kind_d, out_last_q, out_last_d;
  logic [5:0]         out_index_q, out_index_d;
  logic signed [31:0] out_value_q, out_value_d;

  // Shared multiplier operands
  logic               mul_en;
  logic signed [33:0] mul_a, mul_b;

  // Memories
  logic               sram_we, gram_we;
  logic [SW-1:0]      sram_waddr, sram_raddr;
  logic [31:0]        sram_wdata;
  logic signed [31:0] s_rd, q_rd, k_rd, v_rd, gate_rd, g_rd;
  logic               buf_we;

  // Divider
  logic               div_start;
  logic [31:0]        div_den;
  logic [63:0]        div_num, div_quot;
  div_stat_t          div_stat;

  // Derived values
  logic signed [63:0] prodsh;
  logic signed [31:0] sat_p;
  logic signed [33:0] y_c;
  logic [31:0]        e_p, e_res;
  logic signed [34:0] e_sh, e_nsh;
  logic [63:0]        e_r;
  logic               i_last, col_last, out_free;
  logic signed [63:0] acc_n;

  assign buf_we     = in_acc & (in_op == OP_TOKEN) & row_ok;
  assign sram_raddr = ((state_q == S_RD) || (state_q == S_RDOUT)) ? rd_addr_q : {i_q, col_q};

  gdr_ram #(.WIDTH(32), .DEPTH(SDEPTH)) u_state_ram (
    .clk_i(clk_i), .we_i(sram_we), .waddr_i(sram_waddr), .wdata_i(sram_wdata),
    .raddr_i(sram_raddr), .rdata_o(s_rd)
  );
  gdr_ram #(.WIDTH(32), .DEPTH(DIM)) u_q_ram (
    .clk_i(clk_i), .we_i(buf_we), .waddr_i(in_row[AW-1:0]), .wdata_i(in_q),
    .raddr_i(i_q), .rdata_o(q_rd)
  );
  gdr_ram #(.WIDTH(32), .DEPTH(DIM)) u_k_ram (
    .clk_i(clk_i), .we_i(buf_we), .waddr_i(in_row[AW-1:0]), .wdata_i(in_k),
    .raddr_i(i_q), .rdata_o(k_rd)
  );
  gdr_ram #(.WIDTH(32), .DEPTH(DIM)) u_v_ram (
    .clk_i(clk_i), .we_i(buf_we), .waddr_i(in_row[AW-1:0]), .wdata_i(in_v),
    .raddr_i(col_q), .rdata_o(v_rd)
  );
  gdr_ram #(.WIDTH(32), .DEPTH(DIM)) u_gate_ram (
    .clk_i(clk_i), .we_i(buf_we), .waddr_i(in_row[AW-1:0]), .wdata_i(in_gate),
    .raddr_i(i_q), .rdata_o(gate_rd)
  );
  // Exponentiated per-row gates
  gdr_ram #(.WIDTH(32), .DEPTH(DIM)) u_g_ram (
    .clk_i(clk_i), .we_i(gram_we), .waddr_i(i_q), .wdata_i(exp_q),
    .raddr_i(i_q), .rdata_o(g_rd)
  );

  // Sigmoid: (one*one + den/2) / den
  assign div_den = ONE_U + exp_q;
  assign div_num = (64'd1 << (2 * FRAC_BITS)) + 64'(div_den >> 1);

  gdr_div #(.NW(64), .DW(32)) u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .num_i(div_num),
    .den_i(div_den), .quot_o(div_quot), .stat_o(div_stat)
  );

  // Floored product and helpers
  assign prodsh   = 64'(prod_q >>> FRAC_BITS);
  assign sat_p    = sat32(prodsh);
  assign y_c      = 34'(prod_q >>> 30);
  assign i_last   = (i_q == AW'(DIM - 1));
  assign col_last = (col_q == AW'(DIM - 1));
  assign out_free = !out_valid_q || m_axis_tready;
  assign acc_n    = acc_a_q + prodsh;

  // Finish exp: polynomial times 2**n, moved to the working format
  always_comb begin
    e_p   = pacc_q + {2'b00, prod_q[59:30]};
    e_sh  = 35'(n_q) + 35'(FRAC_BITS - 30);
    e_nsh = -e_sh;
    e_r   = {32'b0, e_p} << e_sh[4:0];
    if (!e_sh[34]) begin
      if (e_sh >= 35'sd32) begin
        e_res = 32'h7FFF_FFFF;
      end else if (e_r > 64'h7FFF_FFFF) begin
        e_res = 32'h7FFF_FFFF;
      end else begin
        e_res = e_r[31:0];
      end
    end else if (e_nsh >= 35'sd32) begin
      e_res = '0;
    end else begin
      e_res = e_p >> e_nsh[4:0];
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;  sub_d = sub_q;  i_d = i_q;  col_d = col_q;  clr_d = clr_q;
    per_row_d = per_row_q;  sig_d = sig_q;  scale_d = scale_q;  beta_d = beta_q;
    exp_beta_d = exp_beta_q;  out_valid_d = out_valid_q;
    beta_eff_d = beta_eff_q;  g0_d = g0_q;  kq_d = kq_q;  kv_d = kv_q;  qs_d = qs_q;
    d_d = d_q;  t_d = t_q;  s_d = s_q;  delta_d = delta_q;
    acc_a_d = acc_a_q;  acc_b_d = acc_b_q;  x_d = x_q;  n_d = n_q;
    f30_d = f30_q;  sq_d = sq_q;  pacc_d = pacc_q;  exp_d = exp_q;
    rd_addr_d = rd_addr_q;  rd_ok_d = rd_ok_q;  rd_col_d = rd_col_q;
    out_kind_d = out_kind_q;  out_last_d = out_last_q;
    out_index_d = out_index_q;  out_value_d = out_value_q;
    mul_en = 1'b0;  mul_a = '0;  mul_b = '0;
    sram_we = 1'b0;  sram_waddr = {i_q, col_q};  sram_wdata = '0;
    gram_we = 1'b0;  div_start = 1'b0;

    // Drop the result once taken
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    // Configuration writes
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PER_ROW:  per_row_d = cfg_data_i[0];
        CFG_BETA_SIG: sig_d = cfg_data_i[0];
        CFG_SCALE:    scale_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      // Zero the state RAM after reset
      S_CLR: begin
        sram_we    = 1'b1;
        sram_waddr = clr_q;
        clr_d      = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_WRITE: begin
              if (addr_ok) begin
                sram_we    = 1'b1;
                sram_waddr = in_addr;
                sram_wdata = in_state;
              end
            end
            OP_READ: begin
              rd_addr_d = in_addr;
              rd_ok_d   = addr_ok;
              rd_col_d  = in_col;
              state_d   = S_RD;
            end
            OP_TOKEN: begin
              if (s_axis_tlast) begin
                beta_d  = signed'(in_beta);
                state_d = S_BETA;
              end
            end
            default: ;
          endcase
        end
      end

      S_RD: state_d = S_RDOUT;

      S_RDOUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_READ;
          out_index_d = rd_col_q;
          out_value_d = rd_ok_q ? s_rd : '0;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_BETA: begin
        if (sig_q) begin
          x_d        = -(33'(beta_q));
          exp_beta_d = 1'b1;
          sub_d      = '0;
          state_d    = S_EXP;
        end else begin
          beta_eff_d = beta_q;
          i_d        = '0;
          sub_d      = '0;
          state_d    = S_GATE;
        end
      end

      // exp(x): scale by log2(e), split, polynomial, shift
      S_EXP: begin
        sub_d = sub_q + 1'b1;
        case (sub_q)
          3'd0: begin
            mul_en = 1'b1;  mul_a = 34'(x_q);  mul_b = LOG2E_Q30;
          end
          3'd1: begin
            n_d   = y_c >>> FRAC_BITS;
            f30_d = {y_c[FRAC_BITS-1:0], {(30 - FRAC_BITS){1'b0}}};
          end
          3'd2: begin
            mul_en = 1'b1;  mul_a = $signed({4'b0, f30_q});  mul_b = $signed({4'b0, f30_q});
          end
          3'd3: begin
            sq_d   = prod_q[59:30];
            mul_en = 1'b1;  mul_a = $signed({4'b0, f30_q});  mul_b = EXP_C1;
          end
          3'd4: begin
            pacc_d = ONE_Q30 + {2'b00, prod_q[59:30]};
            mul_en = 1'b1;  mul_a = $signed({4'b0, sq_q});  mul_b = EXP_C2;
          end
          default: begin
            exp_d   = e_res;
            sub_d   = '0;
            state_d = S_EXPRET;
          end
        endcase
      end

      S_EXPRET: begin
        if (exp_beta_q) begin
          exp_beta_d = 1'b0;
          div_start  = 1'b1;
          state_d    = S_DIV;
        end else if (per_row_q && !i_last) begin
          gram_we = 1'b1;
          i_d     = i_q + 1'b1;
          sub_d   = '0;
          state_d = S_GATE;
        end else begin
          gram_we = per_row_q;
          g0_d    = exp_q;
          i_d     = '0;
          sub_d   = '0;
          acc_a_d = '0;
          state_d = S_KQ;
        end
      end

      S_DIV: begin
        if (div_stat.done) begin
          beta_eff_d = div_quot[31:0];
          i_d        = '0;
          sub_d      = '0;
          state_d    = S_GATE;
        end
      end

      // Fetch a gate logit and hand it to exp
      S_GATE: begin
        if (sub_q == 3'd0) begin
          sub_d = 3'd1;
        end else begin
          x_d     = 33'(gate_rd);
          sub_d   = '0;
          state_d = S_EXP;
        end
      end

      // kq = sum k[i]*q[i]
      S_KQ: begin
        sub_d = sub_q + 1'b1;
        if (sub_q == 3'd1) begin
          mul_en = 1'b1;  mul_a = 34'(k_rd);  mul_b = 34'(q_rd);
        end else if (sub_q == 3'd2) begin
          sub_d = '0;
          if (i_last) begin
            kq_d    = sat32(acc_n);
            i_d     = '0;
            col_d   = '0;
            acc_a_d = '0;
            acc_b_d = '0;
            state_d = S_A;
          end else begin
            acc_a_d = acc_n;
            i_d     = i_q + 1'b1;
          end
        end
      end

      // Column sums kv and qs over the gated old state
      S_A: begin
        sub_d = sub_q + 1'b1;
        case (sub_q)
          3'd0: ;
          3'd1: begin
            mul_en = 1'b1;  mul_a = per_row_q ? 34'(g_rd) : ONE_FX;  mul_b = 34'(s_rd);
          end
          3'd2: s_d = sat_p;
          3'd3: begin
            mul_en = 1'b1;  mul_a = 34'(s_q);  mul_b = 34'(k_rd);
          end
          3'd4: begin
            acc_a_d = acc_a_q + prodsh;
            mul_en  = 1'b1;  mul_a = 34'(s_q);  mul_b = 34'(q_rd);
          end
          default: begin
            acc_b_d = acc_b_q + prodsh;
            sub_d   = '0;
            if (i_last) begin
              state_d = S_FIX;
            end else begin
              i_d = i_q + 1'b1;
            end
          end
        endcase
      end

      // Scalar gate on the sums, then delta
      S_FIX: begin
        sub_d = sub_q + 1'b1;
        case (sub_q)
          3'd0: begin
            kv_d = sat32(acc_a_q);
            qs_d = sat32(acc_b_q);
          end
          3'd1: begin
            mul_en = 1'b1;  mul_a = per_row_q ? ONE_FX : 34'(g0_q);  mul_b = 34'(kv_q);
          end
          3'd2: begin
            kv_d   = sat_p;
            mul_en = 1'b1;  mul_a = per_row_q ? ONE_FX : 34'(g0_q);  mul_b = 34'(qs_q);
          end
          3'd3: begin
            qs_d = sat_p;
            d_d  = sat32(64'(v_rd) - 64'(kv_q));
          end
          3'd4: begin
            mul_en = 1'b1;  mul_a = 34'(d_q);  mul_b = 34'(beta_eff_q);
          end
          default: begin
            delta_d = sat_p;
            i_d     = '0;
            sub_d   = '0;
            state_d = S_B;
          end
        endcase
      end

      // State update of the column
      S_B: begin
        sub_d = sub_q + 1'b1;
        case (sub_q)
          3'd0: ;
          3'd1: begin
            mul_en = 1'b1;  mul_a = per_row_q ? 34'(g_rd) : 34'(g0_q);  mul_b = 34'(s_rd);
          end
          3'd2: begin
            t_d    = sat_p;
            mul_en = 1'b1;  mul_a = 34'(k_rd);  mul_b = 34'(delta_q);
          end
          default: begin
            sram_we    = 1'b1;
            sram_wdata = sat32(64'(t_q) + 64'(sat_p));
            sub_d      = '0;
            if (i_last) begin
              state_d = S_OUT;
            end else begin
              i_d = i_q + 1'b1;
            end
          end
        endcase
      end

      // Output element of the column
      S_OUT: begin
        sub_d = sub_q + 1'b1;
        case (sub_q)
          3'd0: begin
            mul_en = 1'b1;  mul_a = 34'(delta_q);  mul_b = 34'(kq_q);
          end
          3'd1: d_d = sat32(64'(qs_q) + 64'(sat_p));
          3'd2: begin
            mul_en = 1'b1;  mul_a = 34'(d_q);  mul_b = $signed({17'b0, scale_q});
          end
          default: begin
            sub_d = sub_q;
            if (out_free) begin
              out_valid_d = 1'b1;
              out_kind_d  = KIND_ATTN;
              out_index_d = 6'(col_q);
              out_value_d = sat_p;
              out_last_d  = col_last;
              sub_d       = '0;
              i_d         = '0;
              acc_a_d     = '0;
              acc_b_d     = '0;
              if (col_last) begin
                state_d = S_IDLE;
              end else begin
                col_d   = col_q + 1'b1;
                state_d = S_A;
              end
            end
          end
        endcase
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      sub_q       <= '0;
      i_q         <= '0;
      col_q       <= '0;
      clr_q       <= '0;
      per_row_q   <= 1'b0;
      sig_q       <= 1'b0;
      scale_q     <= SCALE_RESET;
      beta_q      <= '0;
      exp_beta_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sub_q       <= sub_d;
      i_q         <= i_d;
      col_q       <= col_d;
      clr_q       <= clr_d;
      per_row_q   <= per_row_d;
      sig_q       <= sig_d;
      scale_q     <= scale_d;
      beta_q      <= beta_d;
      exp_beta_q  <= exp_beta_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    beta_eff_q  <= beta_eff_d;
    g0_q        <= g0_d;
    kq_q        <= kq_d;
    kv_q        <= kv_d;
    qs_q        <= qs_d;
    d_q         <= d_d;
    t_q         <= t_d;
    s_q         <= s_d;
    delta_q     <= delta_d;
    acc_a_q     <= acc_a_d;
    acc_b_q     <= acc_b_d;
    x_q         <= x_d;
    n_q         <= n_d;
    f30_q       <= f30_d;
    sq_q        <= sq_d;
    pacc_q      <= pacc_d;
    exp_q       <= exp_d;
    rd_addr_q   <= rd_addr_d;
    rd_ok_q     <= rd_ok_d;
    rd_col_q    <= rd_col_d;
    out_kind_q  <= out_kind_d;
    out_last_q  <= out_last_d;
    out_index_q <= out_index_d;
    out_value_q <= out_value_d;
    if (mul_en) begin
      prod_q <= prod_d;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_value_q, out_index_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

FILE: sv/gdr_checker.sv
// ----------------------------------------------------------------------------
// gdr_checker
// Port-level checks for the gated delta rule recurrence block.
// ----------------------------------------------------------------------------
`default_nettype none

module gdr_checker
  import gdr_pkg::*;
#(
  parameter int DIM = 64
) (
  input wire          clk_i,
  input wire          rst_ni,
  input wire          s_axis_tvalid,
  input wire          s_axis_tready,
  input wire [1:0]    s_axis_tuser,
  input wire          s_axis_tlast,
  input wire          m_axis_tvalid,
  input wire          m_axis_tready,
  input wire [39:0]   m_axis_tdata,
  input wire          m_axis_tuser,
  input wire          m_axis_tlast
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // A read request keeps the block busy until its result is staged
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_READ |=> !s_axis_tready)
    else $error("request taken during a state read");

  // The last row of a token starts an update that blocks new requests
  a_token_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_TOKEN && s_axis_tlast
    |=> !s_axis_tready)
    else $error("request taken during a token update");

  // Read data always closes its run
  a_read_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_READ |-> m_axis_tlast)
    else $error("state read result without last");

  // Only the final column closes an attention run
  a_attn_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_ATTN && m_axis_tlast
    |-> m_axis_tdata[5:0] == 6'(DIM - 1))
    else $error("attention run closed early");

endmodule

bind gated_delta_rule_recurrence gdr_checker #(.DIM(DIM)) u_gdr_checker (.*);

`default_nettype wire
